// File: hw/rtl/i2cm_pkg.sv
// Package for the I2C master byte engine: command, state and status codes,
// result type and reset constants. No dependencies.
package i2cm_pkg;

  localparam int unsigned FuncW    = 3;
  localparam int unsigned TickW    = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned CfgAddrW = 3;

  localparam logic [TickW-1:0] HalfPeriodRst = 16'd100;
  localparam logic [TickW-1:0] AckTimeoutRst = 16'd575;

  localparam logic [ByteW-1:0] AddrWrMask = 8'hfe;
  localparam logic [ByteW-1:0] AddrRdBit  = 8'h01;
  localparam logic [ByteW-1:0] MsbMask    = 8'h80;

  typedef enum logic [FuncW-1:0] {
    FUNC_NONE  = 3'd0,
    FUNC_START = 3'd1,
    FUNC_STOP  = 3'd2,
    FUNC_WRITE = 3'd3,
    FUNC_ADDR  = 3'd4,
    FUNC_READ  = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_START    = 3'd1,
    ST_STOP     = 3'd2,
    ST_WRITE    = 3'd3,
    ST_READ     = 3'd4,
    ST_FAILSTOP = 3'd5
  } cmd_state_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK       = 2'd0,
    STAT_BUS_BUSY = 2'd1,
    STAT_BUS_ERR  = 2'd2,
    STAT_ACK_TO   = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    REG_HALF_PERIOD = 1'b0,
    REG_ACK_TIMEOUT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0]   data_byte;
    logic [FuncW-1:0]   func;
    logic               read_dir;
    logic               send_ack;
    logic               sda_in;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0]   rx_data;
    logic [StatusW-1:0] status;
    logic               done_res;
    logic               busy_res;
    logic               sda_out;
    logic               scl_out;
  } result_t;

endpackage

// File: hw/rtl/i2cm_cfg.sv
// APB register file: SCL half period and ACK timeout.
// Depends on i2cm_pkg.
module i2cm_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [i2cm_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [i2cm_pkg::TickW-1:0]     half_period_o,
  output logic [i2cm_pkg::TickW-1:0]     ack_timeout_o
);
  import i2cm_pkg::*;

  logic [TickW-1:0] half_q, half_d, ackto_q, ackto_d;
  logic             wr_en;
  reg_idx_e         idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_e'(paddr[2]);

  always_comb begin
    half_d  = half_q;
    ackto_d = ackto_q;
    if (wr_en) begin
      unique case (idx)
        REG_HALF_PERIOD: half_d  = pwdata[TickW-1:0];
        REG_ACK_TIMEOUT: ackto_d = pwdata[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_HALF_PERIOD: prdata = {{(32-TickW){1'b0}}, half_q};
      REG_ACK_TIMEOUT: prdata = {{(32-TickW){1'b0}}, ackto_q};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q  <= HalfPeriodRst;
      ackto_q <= AckTimeoutRst;
    end else begin
      half_q  <= half_d;
      ackto_q <= ackto_d;
    end
  end

  assign half_period_o = half_q;
  assign ack_timeout_o = ackto_q;

endmodule

// File: hw/rtl/i2cm_engine.sv
// Bit-level I2C sequencer: command state, phase, shift and timing counters.
// Advances one tick per enabled cycle. Depends on i2cm_pkg.
module i2cm_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  i2cm_pkg::item_t             item_i,
  input  logic [i2cm_pkg::TickW-1:0]  half_period_i,
  input  logic [i2cm_pkg::TickW-1:0]  ack_timeout_i,
  output i2cm_pkg::result_t           result_o
);
  import i2cm_pkg::*;

  cmd_state_e       state_q, state_d;
  logic [2:0]       phase_q, phase_d;
  logic [3:0]       bitc_q, bitc_d;
  logic [ByteW-1:0] shift_q, shift_d;
  logic [TickW-1:0] delay_q, delay_d;
  logic [TickW-1:0] ackw_q, ackw_d;
  logic             scl_q, scl_d, sda_q, sda_d;
  status_e          status_q, status_d;
  logic [ByteW-1:0] rx_q, rx_d;
  logic             ackc_q, ackc_d;
  logic             done;
  logic             run;
  logic [TickW-1:0] hold_val;

  assign hold_val = (half_period_i == '0) ? TickW'(1) : half_period_i;

  // next state of the sequencer
  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    bitc_d   = bitc_q;
    shift_d  = shift_q;
    delay_d  = delay_q;
    ackw_d   = ackw_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    status_d = status_q;
    rx_d     = rx_q;
    ackc_d   = ackc_q;
    done     = 1'b0;
    run      = 1'b0;

    if (state_q == ST_IDLE) begin
      if (item_i.func >= FUNC_START && item_i.func <= FUNC_READ) begin
        phase_d = '0;
        bitc_d  = '0;
        delay_d = '0;
        ackw_d  = '0;
        run     = 1'b1;
        case (func_e'(item_i.func))
          FUNC_START: state_d = ST_START;
          FUNC_STOP:  state_d = ST_STOP;
          FUNC_WRITE: begin
            state_d = ST_WRITE;
            shift_d = item_i.data_byte;
          end
          FUNC_ADDR: begin
            state_d = ST_WRITE;
            shift_d = item_i.read_dir ? (item_i.data_byte | AddrRdBit)
                                      : (item_i.data_byte & AddrWrMask);
          end
          default: begin
            state_d = ST_READ;
            shift_d = '0;
            ackc_d  = item_i.send_ack;
          end
        endcase
      end
    end else if (delay_q > TickW'(1)) begin
      delay_d = delay_q - TickW'(1);
    end else begin
      delay_d = '0;
      run     = 1'b1;
    end

    if (run) begin
      unique case (state_d)
        ST_START: begin
          case (phase_d)
            3'd0: begin sda_d = 1'b1; delay_d = hold_val; phase_d = 3'd1; end
            3'd1: begin scl_d = 1'b1; delay_d = hold_val; phase_d = 3'd2; end
            3'd2: begin
              if (!item_i.sda_in) begin
                state_d = ST_IDLE; phase_d = '0; delay_d = '0;
                status_d = STAT_BUS_BUSY; done = 1'b1;
              end else begin
                sda_d = 1'b0; delay_d = hold_val; phase_d = 3'd3;
              end
            end
            3'd3: begin scl_d = 1'b0; delay_d = hold_val; phase_d = 3'd4; end
            default: begin
              state_d = ST_IDLE; phase_d = '0; delay_d = '0;
              status_d = item_i.sda_in ? STAT_BUS_ERR : STAT_OK; done = 1'b1;
            end
          endcase
        end
        ST_STOP, ST_FAILSTOP: begin
          case (phase_d)
            3'd0: begin sda_d = 1'b0; delay_d = hold_val; phase_d = 3'd1; end
            3'd1: begin scl_d = 1'b1; delay_d = hold_val; phase_d = 3'd2; end
            3'd2: begin sda_d = 1'b1; delay_d = hold_val; phase_d = 3'd3; end
            default: begin
              status_d = (state_d == ST_FAILSTOP) ? STAT_ACK_TO : STAT_OK;
              state_d = ST_IDLE; phase_d = '0; delay_d = '0; done = 1'b1;
            end
          endcase
        end
        ST_WRITE: begin
          case (phase_d)
            3'd0: begin
              scl_d   = 1'b0;
              sda_d   = (shift_d & MsbMask) != '0;
              shift_d = {shift_d[ByteW-2:0], 1'b0};
              bitc_d  = bitc_d + 4'd1;
              delay_d = hold_val;
              phase_d = 3'd1;
            end
            3'd1: begin scl_d = 1'b1; delay_d = hold_val; phase_d = 3'd2; end
            3'd2: begin
              scl_d   = 1'b0;
              delay_d = hold_val;
              phase_d = (bitc_d >= 4'd8) ? 3'd3 : 3'd0;
            end
            3'd3: begin
              sda_d = 1'b1; delay_d = hold_val; phase_d = 3'd4; ackw_d = '0;
            end
            3'd4: begin scl_d = 1'b1; delay_d = hold_val; phase_d = 3'd5; end
            default: begin
              if (!item_i.sda_in) begin
                scl_d = 1'b0;
                state_d = ST_IDLE; phase_d = '0; delay_d = '0;
                status_d = STAT_OK; done = 1'b1;
              end else if (ackw_d >= ack_timeout_i) begin
                state_d = ST_FAILSTOP;
                sda_d   = 1'b0;
                delay_d = hold_val;
                phase_d = 3'd1;
              end else begin
                ackw_d = ackw_d + TickW'(1);
              end
            end
          endcase
        end
        ST_READ: begin
          case (phase_d)
            3'd0: begin
              sda_d = 1'b1; scl_d = 1'b0; delay_d = hold_val; phase_d = 3'd1;
            end
            3'd1: begin scl_d = 1'b1; delay_d = hold_val; phase_d = 3'd2; end
            3'd2: begin
              shift_d = {shift_d[ByteW-2:0], item_i.sda_in};
              bitc_d  = bitc_d + 4'd1;
              scl_d   = 1'b0;
              delay_d = hold_val;
              phase_d = (bitc_d >= 4'd8) ? 3'd3 : 3'd1;
            end
            3'd3: begin
              sda_d = ~ackc_d; delay_d = hold_val; phase_d = 3'd4;
            end
            3'd4: begin scl_d = 1'b1; delay_d = hold_val; phase_d = 3'd5; end
            3'd5: begin scl_d = 1'b0; delay_d = hold_val; phase_d = 3'd6; end
            default: begin
              rx_d = shift_d;
              state_d = ST_IDLE; phase_d = '0; delay_d = '0;
              status_d = STAT_OK; done = 1'b1;
            end
          endcase
        end
        default: begin
          state_d = ST_IDLE; phase_d = '0; delay_d = '0;
          status_d = STAT_OK; done = 1'b1;
        end
      endcase
    end
  end

  // result seen on this tick
  always_comb begin
    result_o.scl_out  = scl_d;
    result_o.sda_out  = sda_d;
    result_o.busy_res = (state_d != ST_IDLE);
    result_o.done_res = done;
    result_o.status   = status_d;
    result_o.rx_data  = rx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      phase_q  <= '0;
      bitc_q   <= '0;
      shift_q  <= '0;
      delay_q  <= '0;
      ackw_q   <= '0;
      scl_q    <= 1'b1;
      sda_q    <= 1'b1;
      status_q <= STAT_OK;
      rx_q     <= '0;
      ackc_q   <= 1'b0;
    end else if (en_i) begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      bitc_q   <= bitc_d;
      shift_q  <= shift_d;
      delay_q  <= delay_d;
      ackw_q   <= ackw_d;
      scl_q    <= scl_d;
      sda_q    <= sda_d;
      status_q <= status_d;
      rx_q     <= rx_d;
      ackc_q   <= ackc_d;
    end
  end

endmodule

// File: hw/rtl/i2c_master_byte_engine_top.sv
// I2C master byte engine top level: input register, sequencer, result register
// and APB configuration. Depends on i2cm_pkg, i2cm_cfg and i2cm_engine.
//
// Each input item is one tick of the bus timing: it carries the sampled SDA
// level and, while the engine is idle, a command. Every item yields exactly
// one result item with the SCL/SDA drive, busy, a done pulse, status and the
// last received byte. Items pass through an input register and a result
// register, one item per cycle sustained while m_axis_tready holds; a result
// becomes valid when its item moves from the input register into the result
// register. The sequencer state advances only on that move, so stalls on
// either side never change the timing counted in ticks. Write the
// configuration registers only while no command is running.
module i2c_master_byte_engine_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] data_byte, [8] read_dir, [9] send_ack, [10] sda_in, [15:11] zero
  input  logic [i2cm_pkg::InDataW-1:0]      s_axis_tdata,
  // [2:0] func
  input  logic [i2cm_pkg::FuncW-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [5:4] status,
  // [13:6] rx_data, [15:14] zero
  output logic [i2cm_pkg::OutDataW-1:0]     m_axis_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [i2cm_pkg::CfgAddrW-1:0]     paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import i2cm_pkg::*;

  logic             in_vld_q, in_vld_d;
  item_t            in_item_q;
  logic             out_vld_q, out_vld_d;
  result_t          out_res_q;
  result_t          res;
  logic             step;
  logic [TickW-1:0] half_period, ack_timeout;

  i2cm_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .half_period_o (half_period),
    .ack_timeout_o (ack_timeout)
  );

  i2cm_engine u_engine (
    .clk_i,
    .rst_ni,
    .en_i          (step),
    .item_i        (in_item_q),
    .half_period_i (half_period),
    .ack_timeout_i (ack_timeout),
    .result_o      (res)
  );

  assign step          = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | step;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_axis_tready) in_vld_d = s_axis_tvalid;
    out_vld_d = out_vld_q;
    if (~out_vld_q | m_axis_tready) out_vld_d = in_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.data_byte <= s_axis_tdata[ByteW-1:0];
      in_item_q.read_dir  <= s_axis_tdata[8];
      in_item_q.send_ack  <= s_axis_tdata[9];
      in_item_q.sda_in    <= s_axis_tdata[10];
      in_item_q.func      <= s_axis_tuser;
    end
    if (step) out_res_q <= res;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW-14){1'b0}}, out_res_q.rx_data, out_res_q.status,
                          out_res_q.done_res, out_res_q.busy_res, out_res_q.sda_out,
                          out_res_q.scl_out};

endmodule
